/* sv/pidci_pkg.sv */
// Shared constants, types and microcode ROM for the clamped-integral PID core.
// Used by the sequencer, the datapath, the divider and the top level.
// No dependencies.
package pidci_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int INT_BITS   = DATA_WIDTH - FRAC_BITS;
    localparam int DT_WIDTH   = 8 + FRAC_BITS;
    localparam int IN_WIDTH   = ((DATA_WIDTH + DT_WIDTH + 7) / 8) * 8;
    localparam int OUT_WIDTH  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 4;
    localparam int DIV_CNT_W  = $clog2(DATA_WIDTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_INT_LIMIT = 3'd4,
        REG_OUT_BIAS  = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_ERR,
        OP_DIFF,
        OP_DINIT,
        OP_DIV,
        OP_DFIN,
        OP_MUL_ED,
        OP_INTEG,
        OP_MUL_PE,
        OP_ACC_LOAD,
        OP_MUL_DD,
        OP_ACC_ADD,
        OP_MUL_II,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_DTZ,
        C_LOOP,
        C_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic en;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic dt_zero;
        logic div_last;
    } status_t;

    localparam logic [STEP_W-1:0] STEP_LOAD   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_ED = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NONE   = 4'd0;

    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
        uword_t w;
        case (addr)
            4'd0:    w = '{op: OP_LOAD,     cond: C_WAIT_IN,  target: STEP_NONE};
            4'd1:    w = '{op: OP_ERR,      cond: C_NEXT,     target: STEP_NONE};
            4'd2:    w = '{op: OP_DIFF,     cond: C_NEXT,     target: STEP_NONE};
            4'd3:    w = '{op: OP_DINIT,    cond: C_DTZ,      target: STEP_MUL_ED};
            4'd4:    w = '{op: OP_DIV,      cond: C_LOOP,     target: STEP_NONE};
            4'd5:    w = '{op: OP_DFIN,     cond: C_NEXT,     target: STEP_NONE};
            4'd6:    w = '{op: OP_MUL_ED,   cond: C_NEXT,     target: STEP_NONE};
            4'd7:    w = '{op: OP_INTEG,    cond: C_NEXT,     target: STEP_NONE};
            4'd8:    w = '{op: OP_MUL_PE,   cond: C_NEXT,     target: STEP_NONE};
            4'd9:    w = '{op: OP_ACC_LOAD, cond: C_NEXT,     target: STEP_NONE};
            4'd10:   w = '{op: OP_MUL_DD,   cond: C_NEXT,     target: STEP_NONE};
            4'd11:   w = '{op: OP_ACC_ADD,  cond: C_NEXT,     target: STEP_NONE};
            4'd12:   w = '{op: OP_MUL_II,   cond: C_NEXT,     target: STEP_NONE};
            4'd13:   w = '{op: OP_ACC_ADD,  cond: C_NEXT,     target: STEP_NONE};
            4'd14:   w = '{op: OP_OUT,      cond: C_WAIT_OUT, target: STEP_LOAD};
            default: w = '{op: OP_LOAD,     cond: C_WAIT_IN,  target: STEP_NONE};
        endcase
        return w;
    endfunction

endpackage

/* sv/pidci_seq.sv */
// Microcode sequencer: step counter, control ROM lookup and jump conditions.
// Depends on pidci_pkg.
module pidci_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  pidci_pkg::status_t status,
    output pidci_pkg::ctrl_t   ctrl
);
    import pidci_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;

    assign uw = ucode_rom(step_reg);

    always_comb begin
        step_next = step_reg;
        ctrl.op   = uw.op;
        ctrl.en   = 1'b1;
        case (uw.cond)
            C_NEXT: begin
                step_next = step_reg + STEP_W'(1);
            end
            C_WAIT_IN: begin
                ctrl.en = status.in_valid;
                if (status.in_valid) begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            C_DTZ: begin
                step_next = status.dt_zero ? uw.target : step_reg + STEP_W'(1);
            end
            C_LOOP: begin
                if (status.div_last) begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            C_WAIT_OUT: begin
                ctrl.en = status.out_free;
                if (status.out_free) begin
                    step_next = uw.target;
                end
            end
            default: begin
                step_next = STEP_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* sv/pidci_div.sv */
// Radix-2 restoring divider for the derivative: (|diff| << FRAC_BITS) / dt.
// One quotient bit per cycle; flags a quotient that does not fit DATA_WIDTH bits.
// Depends on pidci_pkg.
module pidci_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic                              advance,
    input  logic [pidci_pkg::DATA_WIDTH:0]    num_mag,
    input  logic [pidci_pkg::DT_WIDTH-1:0]    dt,
    output logic [pidci_pkg::DATA_WIDTH-1:0]  quot,
    output logic                              ovf,
    output logic                              last
);
    import pidci_pkg::*;

    logic [DT_WIDTH-1:0]   rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] low_reg;
    logic [DATA_WIDTH-1:0] quot_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  ovf_reg;
    logic [DT_WIDTH:0]     trial;
    logic [DT_WIDTH+1:0]   sub;
    logic                  fits;
    logic [DATA_WIDTH:0]   num_hi;

    assign num_hi = num_mag >> INT_BITS;
    assign trial  = {rem_reg, low_reg[DATA_WIDTH-1]};
    assign sub    = {1'b0, trial} - {2'b00, dt};
    assign fits   = !sub[DT_WIDTH+1];
    assign rem_next = fits ? sub[DT_WIDTH-1:0] : trial[DT_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            // upper part of the dividend seeds the remainder
            rem_reg  <= DT_WIDTH'(num_hi);
            low_reg  <= {num_mag[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
            ovf_reg  <= num_hi >= {{(DATA_WIDTH+1-DT_WIDTH){1'b0}}, dt};
        end else if (advance) begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[DATA_WIDTH-2:0], 1'b0};
            quot_reg <= {quot_reg[DATA_WIDTH-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(DATA_WIDTH - 1);
        end else if (advance) begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    assign quot = quot_reg;
    assign ovf  = ovf_reg;
    assign last = (cnt_reg == '0);

endmodule

/* sv/pidci_dp.sv */
// Datapath of the PID core: config registers, controller state, shared
// multiplier, accumulator and output register, driven by the control word.
// Depends on pidci_pkg and pidci_div.
module pidci_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pidci_pkg::ctrl_t                  ctrl,
    output pidci_pkg::status_t                status,
    input  logic                              s_tvalid,
    input  logic [pidci_pkg::IN_WIDTH-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pidci_pkg::OUT_WIDTH-1:0]   m_tdata,
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidci_pkg::DATA_WIDTH-1:0]  cfg_data
);
    import pidci_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int AW = DATA_WIDTH + 3;
    localparam logic [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
        return v[DW-1] ? (DW'(0) - v) : v;
    endfunction

    // configuration
    logic [DW-1:0]   setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DW-2:0]   int_limit_reg, out_bias_reg;

    // per-item working registers
    logic [DW-1:0]   meas_reg;
    logic [DT_WIDTH-1:0] dt_reg;
    logic [DW-1:0]   err_reg, deriv_reg;
    logic [DW:0]     diff_reg;
    logic [2*DW-1:0] prod_reg;
    logic            pneg_reg;
    logic [AW-1:0]   acc_reg;
    logic            flag_reg;

    // controller state
    logic [DW-1:0]   last_err_reg, integ_reg;

    // output register
    logic            out_valid_reg;
    logic [DW-1:0]   out_data_reg;
    logic            out_user_reg;

    logic            run;
    logic            dt_zero;

    assign run     = ctrl.en;
    assign dt_zero = (dt_reg == '0);

    // error
    logic [DW:0]   err_full;
    logic          err_over;
    logic [DW-1:0] err_sat;
    assign err_full = {setpoint_reg[DW-1], setpoint_reg} - {meas_reg[DW-1], meas_reg};
    assign err_over = err_full[DW] != err_full[DW-1];
    assign err_sat  = err_over ? (err_full[DW] ? NEG_LIM : POS_LIM) : err_full[DW-1:0];

    // divider
    logic          diff_neg;
    logic [DW:0]   diff_mag;
    logic [DW-1:0] quot;
    logic          div_ovf, div_last;
    logic [DW-1:0] dlim, dmag;
    logic          dover;
    assign diff_neg = diff_reg[DW];
    assign diff_mag = diff_neg ? ((DW+1)'(0) - diff_reg) : diff_reg;

    pidci_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.op == OP_DINIT),
        .advance (ctrl.op == OP_DIV),
        .num_mag (diff_mag),
        .dt      (dt_reg),
        .quot    (quot),
        .ovf     (div_ovf),
        .last    (div_last)
    );

    assign dlim  = diff_neg ? NEG_LIM : POS_LIM;
    assign dover = div_ovf || (quot > dlim);
    assign dmag  = dover ? dlim : quot;

    // multiplier operand select
    logic [DW-1:0] mul_a, mul_b;
    logic          mul_en;
    always_comb begin
        mul_en = 1'b1;
        case (ctrl.op)
            OP_MUL_ED: begin
                mul_a = err_reg;
                mul_b = DW'(dt_reg);
            end
            OP_MUL_PE: begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            OP_MUL_DD: begin
                mul_a = gain_d_reg;
                mul_b = deriv_reg;
            end
            OP_MUL_II: begin
                mul_a = gain_i_reg;
                mul_b = integ_reg;
            end
            default: begin
                mul_a  = err_reg;
                mul_b  = err_reg;
                mul_en = 1'b0;
            end
        endcase
    end

    // product scaling: drop fraction bits toward zero, then saturate
    logic [2*DW-1:0] scaled;
    logic [DW-1:0]   plim, pmag, term;
    logic            pover;
    assign scaled = prod_reg >> FRAC_BITS;
    assign plim   = pneg_reg ? NEG_LIM : POS_LIM;
    assign pover  = (|scaled[2*DW-1:DW]) || (scaled[DW-1:0] > plim);
    assign pmag   = pover ? plim : scaled[DW-1:0];
    assign term   = pneg_reg ? (DW'(0) - pmag) : pmag;

    // integral update and clamp
    logic signed [DW:0] isum, ilim, ilim_n, iclamp;
    assign isum   = $signed({integ_reg[DW-1], integ_reg}) + $signed({term[DW-1], term});
    assign ilim   = $signed({2'b00, int_limit_reg});
    assign ilim_n = -ilim;
    always_comb begin
        if (isum > ilim) begin
            iclamp = ilim;
        end else if (isum < ilim_n) begin
            iclamp = ilim_n;
        end else begin
            iclamp = isum;
        end
    end

    // output bias and saturation
    logic [AW-1:0]   term_ext, bias_ext, biased;
    logic            acc_pos, acc_neg, out_over;
    logic [DW-1:0]   out_sat;
    assign term_ext = {{3{term[DW-1]}}, term};
    assign bias_ext = {4'b0000, out_bias_reg};
    assign acc_neg  = acc_reg[AW-1];
    assign acc_pos  = !acc_reg[AW-1] && (|acc_reg);
    always_comb begin
        if (acc_pos) begin
            biased = acc_reg + bias_ext;
        end else if (acc_neg) begin
            biased = acc_reg - bias_ext;
        end else begin
            biased = acc_reg;
        end
    end
    assign out_over = !((&biased[AW-1:DW-1]) || !(|biased[AW-1:DW-1]));
    assign out_sat  = out_over ? (biased[AW-1] ? NEG_LIM : POS_LIM) : biased[DW-1:0];

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            int_limit_reg <= '1;
            out_bias_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SETPOINT:  setpoint_reg  <= cfg_data;
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                REG_INT_LIMIT: int_limit_reg <= cfg_data[DW-2:0];
                REG_OUT_BIAS:  out_bias_reg  <= cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= (2*DW)'(mag_of(mul_a)) * (2*DW)'(mag_of(mul_b));
            pneg_reg <= mul_a[DW-1] ^ mul_b[DW-1];
        end
        case (ctrl.op)
            OP_LOAD: begin
                if (run) begin
                    meas_reg <= s_tdata[DW-1:0];
                    dt_reg   <= s_tdata[DW+DT_WIDTH-1:DW];
                    flag_reg <= 1'b0;
                end
            end
            OP_ERR: begin
                err_reg  <= err_sat;
                flag_reg <= flag_reg | err_over;
            end
            OP_DIFF: begin
                diff_reg <= {err_reg[DW-1], err_reg} - {last_err_reg[DW-1], last_err_reg};
            end
            OP_DINIT: begin
                // zero time step: derivative follows the sign of the change
                if (dt_zero) begin
                    flag_reg <= 1'b1;
                    if (diff_neg) begin
                        deriv_reg <= NEG_LIM;
                    end else if (|diff_reg) begin
                        deriv_reg <= POS_LIM;
                    end else begin
                        deriv_reg <= '0;
                    end
                end
            end
            OP_DFIN: begin
                deriv_reg <= diff_neg ? (DW'(0) - dmag) : dmag;
                flag_reg  <= flag_reg | dover;
            end
            OP_ACC_LOAD: begin
                acc_reg  <= term_ext;
                flag_reg <= flag_reg | pover;
            end
            OP_ACC_ADD: begin
                acc_reg  <= acc_reg + term_ext;
                flag_reg <= flag_reg | pover;
            end
            OP_INTEG: begin
                flag_reg <= flag_reg | pover;
            end
            OP_OUT: begin
                if (run) begin
                    out_data_reg <= out_sat;
                    out_user_reg <= flag_reg | out_over;
                end
            end
            default: ;
        endcase
    end

    // controller state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.op == OP_INTEG) begin
                integ_reg    <= iclamp[DW-1:0];
                last_err_reg <= err_reg;
            end
            if (ctrl.op == OP_OUT && run) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.in_valid = s_tvalid;
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.dt_zero  = dt_zero;
    assign status.div_last = div_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_WIDTH'(out_data_reg);
    assign m_tuser  = out_user_reg;

endmodule

/* sv/pid_controller_clamped_integral_core.sv */
// PID controller with clamped integral, Q16.16 fixed point.
//
// Input stream: s_tdata carries one measurement and the elapsed time step.
// Output stream: m_tdata carries the drive value, m_tuser the saturation flag.
// Configuration: cfg_valid/cfg_index/cfg_data write register cfg_index
// (0 setpoint, 1 gain_p, 2 gain_i, 3 gain_d, 4 integral_limit, 5 output_bias);
// cfg_ready is always high; write only while no transaction is in flight.
// The sequencer works on one item at a time. The radix-2 divider for the
// derivative runs unless time_step is zero, and the shared multiplier forms
// four products, one on every other step. s_tready rises once the sequencer
// returns to its first step. The result is registered in the output register
// at the last step.
// Reset clears the configuration to its defaults, the stored last error and
// integral to zero, and drops m_tvalid. While the receiver stalls, the
// finished result holds in the output register; the next item is still taken
// and worked on, and its result waits at the last step for the register.
// Depends on pidci_pkg, pidci_seq, pidci_dp and pidci_div.
module pid_controller_clamped_integral_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] measurement, [55:32] time_step
    input  logic [pidci_pkg::IN_WIDTH-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] drive
    output logic [pidci_pkg::OUT_WIDTH-1:0]   m_tdata,
    // [0] saturated
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidci_pkg::DATA_WIDTH-1:0]  cfg_data
);
    import pidci_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    pidci_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    pidci_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign s_tready  = (ctrl.op == OP_LOAD);
    assign cfg_ready = 1'b1;

endmodule
